FILE: rtl/rws_pkg.sv
// package for the roulette wheel selector: widths, defaults, codes and states
package rws_pkg;

   // default sizing of the fitness table
   localparam int ENTRY_COUNT_DEF  = 64;
   localparam int FITNESS_BITS_DEF = 16;

   // fixed field widths of the channels
   localparam int OP_W       = 1;
   localparam int INDEX_W    = 6;
   localparam int FIT_IN_W   = 16;
   localparam int RANDOM_W   = 32;
   localparam int POP_CNT_W  = 7;
   localparam int BIT_CNT_W  = $clog2(RANDOM_W);

   localparam logic [POP_CNT_W-1:0] POP_CNT_RESET = 7'd64;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE  = 1'b0,
      OP_SELECT = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_MOD,
      ST_WALK,
      ST_RESP
   } state_type;

endpackage

FILE: rtl/rws_if.sv
// valid/ready channel interfaces for request and response beats

interface rws_req_if;
   import rws_pkg::*;

   logic                valid;
   logic                ready;
   op_type              op;
   logic [INDEX_W-1:0]  entry_index;
   logic [FIT_IN_W-1:0] fitness;
   logic [RANDOM_W-1:0] random_word;

   modport source (output valid, output op, output entry_index, output fitness,
                   output random_word, input ready);
   modport sink   (input valid, input op, input entry_index, input fitness,
                   input random_word, output ready);
endinterface

interface rws_rsp_if;
   import rws_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] chosen_index;
   logic               zero_total;

   modport source (output valid, output chosen_index, output zero_total, input ready);
   modport sink   (input valid, input chosen_index, input zero_total, output ready);
endinterface

FILE: rtl/rws_ram.sv
// generic single-write, single-read ram with registered read data
module rws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/roulette_wheel_select.sv
// top level of the roulette wheel selector: fitness table, sequencer and shared adder
//
//   channel   dir   handshake            payload
//   req_bus   in    valid / ready        op, entry_index, fitness, random_word
//   rsp_bus   out   valid / ready        chosen_index, zero_total
//   csr       in    csr_wr_en (no wait)  csr_wr_data = pop_count
//
// a write beat is taken in idle; a select beat sums the first n entries (n = clamped
// pop_count), takes random_word modulo the sum by restoring division, walks the
// entries until one is chosen (a zero sum goes straight to the response), then responds; one adder does all of it
// the table ram has one read port, so sum and walk go one entry per cycle
// reset is synchronous and clears the sequencer and pop_count (to 64); the
// table holds garbage until written
// req_bus.ready is low from select accept until the response beat is taken
module roulette_wheel_select #(
   parameter int ENTRY_COUNT  = rws_pkg::ENTRY_COUNT_DEF,
   parameter int FITNESS_BITS = rws_pkg::FITNESS_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   rws_req_if.sink                         req_bus,
   rws_rsp_if.source                       rsp_bus,
   input  logic                            csr_wr_en,
   input  logic [rws_pkg::POP_CNT_W-1:0]   csr_wr_data
);
   import rws_pkg::*;

   // table address, entry counter, running sum and adder widths
   localparam int IDX_W = $clog2(ENTRY_COUNT);
   localparam int CNT_W = $clog2(ENTRY_COUNT + 1);
   localparam int SUM_W = FITNESS_BITS + CNT_W;
   localparam int U_W   = SUM_W + 1;
   localparam int CMP_W = (CNT_W > POP_CNT_W) ? CNT_W : POP_CNT_W;
   localparam int WA_W  = IDX_W + INDEX_W;
   localparam int FX_W  = FITNESS_BITS + FIT_IN_W;
   localparam int CX_W  = CNT_W + INDEX_W;

   state_type              state_ff, state_in;
   logic [POP_CNT_W-1:0]   pop_count_ff;
   logic [CNT_W-1:0]       n_ff, n_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;      // read issue pointer
   logic                   pend_ff, pend_in;    // read data arrives this cycle
   logic [CNT_W-1:0]       widx_ff, widx_in;    // entry whose data is arriving
   logic [SUM_W-1:0]       acc_ff, acc_in;      // fitness total
   logic [SUM_W-1:0]       rem_ff, rem_in;      // modulo remainder, then walk residue
   logic [RANDOM_W-1:0]    q_ff, q_in;          // dividend shift register
   logic [BIT_CNT_W-1:0]   bit_ff, bit_in;
   logic [INDEX_W-1:0]     chosen_ff, chosen_in;
   logic                   zero_ff, zero_in;

   // table ram signals
   logic                    ram_we;
   logic [IDX_W-1:0]        ram_wr_addr;
   logic [FITNESS_BITS-1:0] ram_wr_data;
   logic [IDX_W-1:0]        ram_rd_addr;
   logic [FITNESS_BITS-1:0] ram_rd_data;

   // shared add / subtract unit
   logic [U_W-1:0] alu_a, alu_b;
   logic           alu_sub;
   logic [U_W:0]   alu_res;
   logic           alu_carry;

   logic [CMP_W-1:0]  pc_ext;
   logic [CNT_W-1:0]  n_clamp;
   logic [WA_W-1:0]   wr_ext;
   logic [FX_W-1:0]   fit_ext;
   logic [CX_W-1:0]   ch_ext;
   logic [U_W-1:0]    shifted;
   logic              idx_ok;

   rws_ram #(
      .WIDTH (FITNESS_BITS),
      .DEPTH (ENTRY_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // write beat: index checked against table size, fitness masked to table width
   assign wr_ext      = WA_W'(req_bus.entry_index);
   assign ram_wr_addr = wr_ext[IDX_W-1:0];
   assign fit_ext     = FX_W'(req_bus.fitness);
   assign ram_wr_data = fit_ext[FITNESS_BITS-1:0];
   assign idx_ok      = (32'(req_bus.entry_index) < 32'(ENTRY_COUNT));
   assign ram_rd_addr = cnt_ff[IDX_W-1:0];

   // pop_count above the table size means the whole table
   assign pc_ext  = CMP_W'(pop_count_ff);
   assign n_clamp = (pc_ext > CMP_W'(ENTRY_COUNT)) ? CNT_W'(ENTRY_COUNT) : CNT_W'(pc_ext);

   // the one adder; carry out high on a subtract means no borrow
   assign alu_res   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                      + (U_W+1)'(alu_sub);
   assign alu_carry = alu_res[U_W];

   // next remainder step of the restoring modulo
   assign shifted = {rem_ff, q_ff[RANDOM_W-1]};
   assign ch_ext  = CX_W'(widx_ff);

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = (state_ff == ST_RESP);
   assign rsp_bus.chosen_index = chosen_ff;
   assign rsp_bus.zero_total   = zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pop_count_ff <= POP_CNT_RESET;
         pend_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         if (csr_wr_en) begin
            pop_count_ff <= csr_wr_data;
         end
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      cnt_ff    <= cnt_in;
      widx_ff   <= widx_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      q_ff      <= q_in;
      bit_ff    <= bit_in;
      chosen_ff <= chosen_in;
      zero_ff   <= zero_in;
   end

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      cnt_in    = cnt_ff;
      pend_in   = pend_ff;
      widx_in   = widx_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      bit_in    = bit_ff;
      chosen_in = chosen_ff;
      zero_in   = zero_ff;
      ram_we    = 1'b0;
      alu_a     = U_W'(acc_ff);
      alu_b     = U_W'(ram_rd_data);
      alu_sub   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            pend_in = 1'b0;
            if (req_bus.valid) begin
               if (req_bus.op == OP_WRITE) begin
                  ram_we = idx_ok;
               end else begin
                  n_in     = n_clamp;
                  q_in     = req_bus.random_word;
                  acc_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_SUM;
               end
            end
         end

         // one table read issued per cycle, added in the following cycle
         ST_SUM: begin
            alu_a   = U_W'(acc_ff);
            alu_b   = U_W'(ram_rd_data);
            alu_sub = 1'b0;
            if (cnt_ff < n_ff) begin
               cnt_in  = cnt_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               acc_in = alu_res[SUM_W-1:0];
            end
            if (cnt_ff == n_ff && !pend_ff) begin
               if (acc_ff == '0) begin
                  zero_in   = 1'b1;
                  chosen_in = '0;
                  state_in  = ST_RESP;
               end else begin
                  zero_in  = 1'b0;
                  rem_in   = '0;
                  bit_in   = '0;
                  state_in = ST_MOD;
               end
            end
         end

         // restoring remainder, one dividend bit per cycle
         ST_MOD: begin
            alu_a   = shifted;
            alu_b   = U_W'(acc_ff);
            alu_sub = 1'b1;
            rem_in  = alu_carry ? alu_res[SUM_W-1:0] : shifted[SUM_W-1:0];
            q_in    = {q_ff[RANDOM_W-2:0], 1'b0};
            bit_in  = bit_ff + BIT_CNT_W'(1);
            if (bit_ff == BIT_CNT_W'(RANDOM_W - 1)) begin
               cnt_in   = '0;
               pend_in  = 1'b0;
               widx_in  = '0;
               state_in = ST_WALK;
            end
         end

         // subtract each fitness; first borrow marks the chosen entry
         ST_WALK: begin
            alu_a   = U_W'(rem_ff);
            alu_b   = U_W'(ram_rd_data);
            alu_sub = 1'b1;
            if (cnt_ff < n_ff) begin
               cnt_in  = cnt_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (alu_carry) begin
                  rem_in  = alu_res[SUM_W-1:0];
                  widx_in = widx_ff + CNT_W'(1);
               end else begin
                  chosen_in = ch_ext[INDEX_W-1:0];
                  state_in  = ST_RESP;
               end
            end else if (cnt_ff == n_ff) begin
               // walk ran off the end, fall back to entry zero
               chosen_in = '0;
               state_in  = ST_RESP;
            end
         end

         ST_RESP: begin
            pend_in = 1'b0;
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
            pend_in  = 1'b0;
         end
      endcase
   end
endmodule

FILE: tb/tb.sv
// testbench for roulette_wheel_select: directed and random beats checked against a predictor
`timescale 1ns / 1ps

module tb;
   import rws_pkg::*;

   // run limits and shadow table depth
   localparam int LAT_WAIT    = 200;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int TABLE_DEPTH = 64;

   // one expected response beat
   typedef struct packed {
      logic [INDEX_W-1:0] chosen_index;
      logic               zero_total;
   } pick_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [POP_CNT_W-1:0] csr_wr_data;

   rws_req_if req_bus ();
   rws_rsp_if rsp_bus ();

   roulette_wheel_select uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow copy of the block state used for prediction
   logic [FIT_IN_W-1:0]  fit_shadow [TABLE_DEPTH];
   logic [POP_CNT_W-1:0] pop_shadow;

   // picks predicted at select accept, oldest first
   pick_type pick_queue [$];

   int unsigned errors;
   int unsigned cycles;
   bit          calm;   // when set, neither side idles

   always #5 clock = ~clock;

   // fitness-proportionate pick over the shadow table
   function automatic pick_type predict_pick(logic [RANDOM_W-1:0] rnd);
      pick_type      p;
      int            n;
      logic [31:0]   total;
      logic [31:0]   rem;
      logic [31:0]   run;
      bit            found;
      n     = (pop_shadow > TABLE_DEPTH) ? TABLE_DEPTH : int'(pop_shadow);
      total = 0;
      for (int i = 0; i < n; i++) total += fit_shadow[i];
      p.chosen_index = '0;
      p.zero_total   = (total == 0);
      if (total != 0) begin
         rem   = rnd % total;
         run   = 0;
         found = 0;
         for (int i = 0; i < n; i++) begin
            run += fit_shadow[i];
            if (!found && rem < run) begin
               p.chosen_index = i[INDEX_W-1:0];
               found = 1;
            end
         end
      end
      return p;
   endfunction

   // drive one request beat and update the shadow state at its accept edge
   task automatic send_beat(op_type op, logic [INDEX_W-1:0] idx, logic [FIT_IN_W-1:0] fit,
                            logic [RANDOM_W-1:0] rnd);
      int idle;
      idle = 0;
      while (!calm && $urandom_range(99) < 30) idle++;
      if (idle > 0) begin
         req_bus.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.op          <= op;
      req_bus.entry_index <= idx;
      req_bus.fitness     <= fit;
      req_bus.random_word <= rnd;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // accepted at this edge
      if (op == OP_WRITE) fit_shadow[idx] = fit;
      else pick_queue.insert(pick_queue.size(), predict_pick(rnd));
   endtask

   task automatic write_fitness(logic [INDEX_W-1:0] idx, logic [FIT_IN_W-1:0] fit);
      send_beat(OP_WRITE, idx, fit, $urandom);
   endtask

   task automatic send_select(logic [RANDOM_W-1:0] rnd);
      send_beat(OP_SELECT, INDEX_W'($urandom_range(63)),
                FIT_IN_W'($urandom_range(16'hFFFF)), rnd);
   endtask

   // sender holds off until every predicted pick has come back
   task automatic wait_for_picks();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pick_queue.size() != 0);
   endtask

   // register write while idle; extra cycles cover a write beat still in flight
   task automatic set_pop_count(logic [POP_CNT_W-1:0] value);
      wait_for_picks();
      repeat (LAT_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      pop_shadow = value;
   endtask

   // fill every entry so no select ever reads an unwritten one
   task automatic test_fill_table();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (i == 0) write_fitness(INDEX_W'(i), 16'hFFFF);
         else if (i == 5) write_fitness(INDEX_W'(i), 16'h0000);
         else write_fitness(INDEX_W'(i), FIT_IN_W'(i * 1237 + 5));
      end
      send_select(32'h0000_0000);
      send_select(32'hFFFF_FFFF);
      send_select(32'h8000_0000);
   endtask

   // zero sum, including a zero register value
   task automatic test_zero_total();
      set_pop_count(7'd0);
      send_select($urandom);
      set_pop_count(7'd1);
      write_fitness(6'd0, 16'h0000);
      send_select(32'hFFFF_FFFF);
      write_fitness(6'd0, 16'hFFFF);
      send_select(32'hFFFF_FFFF);
   endtask

   // register clamp, last entry picked, tiny table
   task automatic test_extremes();
      set_pop_count(7'd127);
      write_fitness(6'd63, 16'hFFFF);
      send_select(32'hFFFF_FFFF);
      send_select(32'h0000_0000);
      set_pop_count(7'd2);
      write_fitness(6'd0, 16'h0000);
      write_fitness(6'd1, 16'h0001);
      send_select(32'hFFFF_FFFF);
      set_pop_count(7'd64);
      send_select(32'h7FFF_FFFF);
   endtask

   // one random phase at a fixed register value
   task automatic test_random_phase(logic [POP_CNT_W-1:0] pop, int beats, bit quiet,
                                    bit hold_off);
      logic [FIT_IN_W-1:0] fit;
      set_pop_count(pop);
      calm = quiet;
      for (int k = 0; k < beats; k++) begin
         if ($urandom_range(1)) begin
            case ($urandom_range(3))
               0:       fit = '0;
               1:       fit = FIT_IN_W'($urandom_range(3));
               default: fit = FIT_IN_W'($urandom_range(16'hFFFF));
            endcase
            write_fitness(INDEX_W'($urandom_range(63)), fit);
         end else begin
            send_select($urandom);
            // pause the sender until the pick is back
            if (hold_off && $urandom_range(3) == 0) wait_for_picks();
         end
      end
      calm = 0;
   endtask

   task automatic end_run();
      wait_for_picks();
      repeat (LAT_WAIT) @(posedge clock);
      if (errors == 0 && pick_queue.size() == 0) begin
         $display("roulette_wheel_select test passed");
      end else begin
         $display("roulette_wheel_select test failed");
      end
      $finish;
   endtask

   // response side: random backpressure and in-order check of every beat
   initial begin
      pick_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pick_queue.size() == 0) begin
               $display("%0t: response beat with no pick pending, got index %0d zero %0b",
                        $time, rsp_bus.chosen_index, rsp_bus.zero_total);
               errors++;
            end else begin
               want = pick_queue.pop_front();
               if (rsp_bus.chosen_index !== want.chosen_index) begin
                  $display("%0t: chosen_index expected %0d actual %0d", $time,
                           want.chosen_index, rsp_bus.chosen_index);
                  errors++;
               end
               if (rsp_bus.zero_total !== want.zero_total) begin
                  $display("%0t: zero_total expected %0b actual %0b", $time,
                           want.zero_total, rsp_bus.zero_total);
                  errors++;
               end
            end
         end
         rsp_bus.ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
      end
   end

   // watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("roulette_wheel_select test failed");
            $finish;
         end
      end
   end

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.op          = OP_WRITE;
      req_bus.entry_index = '0;
      req_bus.fitness     = '0;
      req_bus.random_word = '0;
      errors              = 0;
      calm                = 0;
      pop_shadow          = POP_CNT_RESET;
      for (int i = 0; i < TABLE_DEPTH; i++) fit_shadow[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_table();
      test_zero_total();
      test_extremes();

      // random phases at various register values, one without idling and two with sender hold-offs
      test_random_phase(7'd64, 150, 1'b0, 1'b0);
      test_random_phase(7'd1, 150, 1'b0, 1'b0);
      test_random_phase(7'd2, 150, 1'b0, 1'b1);
      test_random_phase(7'd64, 150, 1'b1, 1'b0);
      test_random_phase(7'd127, 150, 1'b0, 1'b0);
      test_random_phase(7'd0, 100, 1'b0, 1'b0);
      test_random_phase(7'd65, 150, 1'b0, 1'b0);
      test_random_phase(7'd33, 150, 1'b0, 1'b1);
      test_random_phase(POP_CNT_W'($urandom_range(1, 64)), 150, 1'b0, 1'b0);
      test_random_phase(POP_CNT_W'($urandom_range(1, 8)), 150, 1'b0, 1'b0);

      end_run();
   end

endmodule
